@@ rtl/mmic_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the magnetometer min/max calibration block.
// No dependencies; imported by the controller, the datapath and the top level.
package mmic_pkg;

    // Run counter and register widths
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 16'd1000;

    // Configuration address map (byte addresses)
    localparam int ADDR_W = 2;
    localparam logic [ADDR_W-1:0] ADDR_SAMPLE_COUNT = 2'd0;

    // Scale format: unsigned Q4.12; numerator carries one extra bit for rounding
    localparam int SCALE_W   = 16;
    localparam int NUM_SHIFT = 13;
    localparam int STEP_CNT_W = 4;
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = 4'd15;

    // Axis codes
    localparam int NUM_AXES = 3;
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;   // take one sample beat
        logic       div_load;  // set up the division for the selected axis
        logic       div_step;  // one restoring division step
        logic       div_store; // write back the selected axis scale
        logic [1:0] axis;
    } mmic_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic run_end; // the sample being captured closes the run
    } mmic_status_t;

endpackage

@@ rtl/mmic_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the calibration block: sample capture, three divisions, result.
// Depends on mmic_pkg for the command and status structs.
module mmic_ctrl
    import mmic_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  mmic_status_t status,
    output mmic_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [STEP_CNT_W-1:0]   step_reg;
    logic [1:0]              axis_reg;

    // Hold state, step count and axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start && status.run_end)
                    begin
                        state_reg <= ST_LOAD;
                        axis_reg  <= AXIS_X;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_STEP;
                    step_reg  <= '0;
                end
                ST_STEP:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    if (axis_reg == AXIS_Z)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_EMIT:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Decode commands from the current state
    always_comb
    begin
        cmd.capture   = start && (state_reg == ST_IDLE);
        cmd.div_load  = (state_reg == ST_LOAD);
        cmd.div_step  = (state_reg == ST_STEP);
        cmd.div_store = (state_reg == ST_STORE);
        cmd.axis      = axis_reg;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_EMIT);

    // A calculation only starts from a sample beat that closes the run
    a_busy_from_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && $past(status.run_end)))
        else $error("busy rose without a run-closing sample beat");

    // The result strobe lasts one cycle and frees the block
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // Divisions only address real axes
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_load || cmd.div_store) |->
            (axis_reg == AXIS_X || axis_reg == AXIS_Y || axis_reg == AXIS_Z))
        else $error("division on an invalid axis");

    // Every store is preceded by a full set of division steps
    a_store_after_steps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_store |-> ($past(cmd.div_step) && ($past(step_reg) == LAST_STEP)))
        else $error("scale stored before the division finished");

endmodule

@@ rtl/mmic_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: per-axis min/max tracking, run counter, bias adders and a shared
// restoring divider for the soft-iron scales. Depends on mmic_pkg.
module mmic_datapath
    import mmic_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  mmic_cmd_t                       cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]  mag_x,
    input  logic signed [SAMPLE_WIDTH-1:0]  mag_y,
    input  logic signed [SAMPLE_WIDTH-1:0]  mag_z,
    input  logic [COUNT_W-1:0]              sample_count,
    output mmic_status_t                    status,
    output logic signed [SAMPLE_WIDTH:0]    bias_x_half,
    output logic signed [SAMPLE_WIDTH:0]    bias_y_half,
    output logic signed [SAMPLE_WIDTH:0]    bias_z_half,
    output logic [SCALE_W-1:0]              scale_x,
    output logic [SCALE_W-1:0]              scale_y,
    output logic [SCALE_W-1:0]              scale_z,
    output logic                            degenerate
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int SUMW = SW + 2;            // sum of three ranges
    localparam int NW   = SW + 15;           // 8192*sum + 3*r
    localparam int DW   = SW + 3;            // 6*r
    localparam int CW   = DW + SCALE_W;      // saturation compare width
    localparam int PW   = DW + 1;            // partial remainder

    logic signed [SW-1:0]  samp     [NUM_AXES];
    logic signed [SW-1:0]  min_reg  [NUM_AXES];
    logic signed [SW-1:0]  max_reg  [NUM_AXES];
    logic signed [SW-1:0]  min_next [NUM_AXES];
    logic signed [SW-1:0]  max_next [NUM_AXES];
    logic [SW-1:0]         range_w  [NUM_AXES];
    logic signed [SW:0]    diff_w   [NUM_AXES];
    logic [COUNT_W-1:0]    seen_reg;
    logic [COUNT_W-1:0]    seen_next;
    logic [COUNT_W-1:0]    count_inc;
    logic                  run_end;

    logic [SUMW-1:0]       sum_w;
    logic [SW-1:0]         r_sel;
    logic [NW-1:0]         num_w;
    logic [DW-1:0]         den_w;
    logic                  sat_w;

    logic [PW-1:0]         p_reg;
    logic [PW-1:0]         p_next;
    logic [SCALE_W-1:0]    qn_reg;
    logic [SCALE_W-1:0]    qn_next;
    logic [DW-1:0]         den_reg;
    logic                  sat_reg;
    logic [PW-1:0]         trial_w;
    logic                  ge_w;

    logic [SCALE_W-1:0]    scale_reg [NUM_AXES];
    logic                  degen_reg;

    assign samp[0] = mag_x;
    assign samp[1] = mag_y;
    assign samp[2] = mag_z;

    // Close the run when the incremented count reaches the register, or wraps
    assign count_inc = seen_reg + 1'b1;
    assign run_end   = !((count_inc < sample_count) && (count_inc != '0));
    assign status.run_end = run_end;

    // Track min and max; the first sample of a run loads both
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            min_next[i] = min_reg[i];
            max_next[i] = max_reg[i];
            if (cmd.capture)
            begin
                if (seen_reg == '0)
                begin
                    min_next[i] = samp[i];
                    max_next[i] = samp[i];
                end
                else
                begin
                    if (samp[i] < min_reg[i])
                    begin
                        min_next[i] = samp[i];
                    end
                    if (samp[i] > max_reg[i])
                    begin
                        max_next[i] = samp[i];
                    end
                end
            end
        end
    end

    // Advance the run counter; drop back to zero when the run closes
    always_comb
    begin
        seen_next = seen_reg;
        if (cmd.capture)
        begin
            seen_next = run_end ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            min_reg[i] <= min_next[i];
            max_reg[i] <= max_next[i];
        end
    end

    // Ranges and their sum
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            diff_w[i]  = {max_reg[i][SW-1], max_reg[i]} - {min_reg[i][SW-1], min_reg[i]};
            range_w[i] = diff_w[i][SW-1:0];
        end
        sum_w = {2'b00, range_w[0]} + {2'b00, range_w[1]} + {2'b00, range_w[2]};
    end

    // Select the axis being divided
    always_comb
    begin
        case (cmd.axis)
            AXIS_X:  r_sel = range_w[0];
            AXIS_Y:  r_sel = range_w[1];
            AXIS_Z:  r_sel = range_w[2];
            default: r_sel = range_w[0];
        endcase
    end

    // Rounded quotient operands: (8192*sum + 3*r) / (6*r)
    always_comb
    begin
        num_w = {sum_w, {NUM_SHIFT{1'b0}}}
              + {{(NW-SW-1){1'b0}}, r_sel, 1'b0}
              + {{(NW-SW){1'b0}}, r_sel};
        den_w = {1'b0, r_sel, 2'b00} + {2'b00, r_sel, 1'b0};
        // Zero range or a quotient beyond the scale width saturates
        sat_w = ({{(CW-NW){1'b0}}, num_w} >= {den_w, {SCALE_W{1'b0}}});
    end

    // One restoring division step: shift in a numerator bit, subtract if it fits
    always_comb
    begin
        trial_w = {p_reg[DW-1:0], qn_reg[SCALE_W-1]};
        ge_w    = (trial_w >= {1'b0, den_reg});
        p_next  = p_reg;
        qn_next = qn_reg;
        if (cmd.div_load)
        begin
            p_next  = {{(PW-(NW-SCALE_W)){1'b0}}, num_w[NW-1:SCALE_W]};
            qn_next = num_w[SCALE_W-1:0];
        end
        else if (cmd.div_step)
        begin
            p_next  = ge_w ? (trial_w - {1'b0, den_reg}) : trial_w;
            qn_next = {qn_reg[SCALE_W-2:0], ge_w};
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        qn_reg <= qn_next;
        if (cmd.div_load)
        begin
            den_reg <= den_w;
            sat_reg <= sat_w;
        end
    end

    // Write back scales; clear the flag when a run closes, set it on a saturated store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degen_reg <= 1'b0;
        end
        else if (cmd.capture && run_end)
        begin
            degen_reg <= 1'b0;
        end
        else if (cmd.div_store && sat_reg)
        begin
            degen_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            case (cmd.axis)
                AXIS_X:  scale_reg[0] <= sat_reg ? '1 : qn_reg;
                AXIS_Y:  scale_reg[1] <= sat_reg ? '1 : qn_reg;
                AXIS_Z:  scale_reg[2] <= sat_reg ? '1 : qn_reg;
                default: scale_reg[0] <= scale_reg[0];
            endcase
        end
    end

    // Result fields
    assign bias_x_half = {max_reg[0][SW-1], max_reg[0]} + {min_reg[0][SW-1], min_reg[0]};
    assign bias_y_half = {max_reg[1][SW-1], max_reg[1]} + {min_reg[1][SW-1], min_reg[1]};
    assign bias_z_half = {max_reg[2][SW-1], max_reg[2]} + {min_reg[2][SW-1], min_reg[2]};
    assign scale_x     = scale_reg[0];
    assign scale_y     = scale_reg[1];
    assign scale_z     = scale_reg[2];
    assign degenerate  = degen_reg;

    // A run-closing beat leaves the counter at zero
    a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && run_end) |=> (seen_reg == '0))
        else $error("run counter not cleared at end of run");

    // The divider's partial remainder stays below the divisor between steps
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.div_step) && !sat_reg) |-> (p_reg < {1'b0, den_reg}))
        else $error("partial remainder out of range");

    // Only the division path writes the flag high
    a_degen_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(degen_reg) |-> ($past(cmd.div_store) && $past(sat_reg)))
        else $error("degenerate set outside a saturated store");

endmodule

@@ rtl/mag_minmax_iron_calibration_top.sv @@
`timescale 1ns / 1ps
// Top level of the magnetometer min/max hard/soft-iron calibration block.
// Holds the configuration register; depends on mmic_pkg, mmic_ctrl, mmic_datapath.
//
//  channel   handshake                          payload
//  --------  ---------------------------------  ----------------------------------
//  sample    start & !busy                      mag_x, mag_y, mag_z
//  result    done (one cycle, no back-pressure) bias_*_half, scale_*, degenerate
//  config    psel & penable & pwrite & pready   paddr, pwdata (prdata on reads)
//
// A sample beat that does not close the run leaves busy low.
// The beat that closes the run starts three 16-step restoring divisions on one
// shared divider: per axis load, steps and store, then the result; busy stays high.
// The result strobe done lasts one cycle; the receiver cannot stall it.
// Reset is asynchronous, active low; sample_count resets to 1000.
module mag_minmax_iron_calibration_top
    import mmic_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Sample channel
    input  logic                            start,
    output logic                            busy,
    input  logic signed [SAMPLE_WIDTH-1:0]  mag_x,
    input  logic signed [SAMPLE_WIDTH-1:0]  mag_y,
    input  logic signed [SAMPLE_WIDTH-1:0]  mag_z,
    // Result channel
    output logic                            done,
    output logic signed [SAMPLE_WIDTH:0]    bias_x_half,
    output logic signed [SAMPLE_WIDTH:0]    bias_y_half,
    output logic signed [SAMPLE_WIDTH:0]    bias_z_half,
    output logic [SCALE_W-1:0]              scale_x,
    output logic [SCALE_W-1:0]              scale_y,
    output logic [SCALE_W-1:0]              scale_z,
    output logic                            degenerate,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ADDR_W-1:0]               paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [COUNT_W-1:0] sample_count_reg;
    logic [COUNT_W-1:0] sample_count_next;
    logic               cfg_wr;
    mmic_cmd_t          cmd;
    mmic_status_t       status;

    // Configuration register write and readback
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        sample_count_next = sample_count_reg;
        if (cfg_wr && (paddr == ADDR_SAMPLE_COUNT))
        begin
            sample_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_SAMPLE_COUNT)
        begin
            prdata = {{(32-COUNT_W){1'b0}}, sample_count_reg};
        end
    end

    mmic_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mmic_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mag_x        (mag_x),
        .mag_y        (mag_y),
        .mag_z        (mag_z),
        .sample_count (sample_count_reg),
        .status       (status),
        .bias_x_half  (bias_x_half),
        .bias_y_half  (bias_y_half),
        .bias_z_half  (bias_z_half),
        .scale_x      (scale_x),
        .scale_y      (scale_y),
        .scale_z      (scale_z),
        .degenerate   (degenerate)
    );

endmodule
